// ----- rtl/sstg_pkg.sv -----
// Shared types, codes and constants of the sprite scanline texel generator.
package sstg_pkg;

    localparam int DEF_MAX_LOG_SIZE     = 6;
    localparam int DEF_MAX_RASTER_WIDTH = 1024;

    localparam int CW         = 15;
    localparam int MW         = 18;
    localparam int META_AW    = 6;
    localparam int META_DEPTH = 64;
    localparam int COEF_FRAC  = 16;

    localparam logic [31:0] COEF_ONE  = 32'h0001_0000;
    localparam logic [31:0] COEF_ZERO = 32'h0000_0000;
    localparam logic [10:0] RW_RESET  = 11'd640;

    typedef enum logic [1:0] {
        CMD_PLAIN  = 2'd0,
        CMD_AFFINE = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        CFG_A00 = 3'd0,
        CFG_A01 = 3'd1,
        CFG_B0  = 3'd2,
        CFG_A10 = 3'd3,
        CFG_A11 = 3'd4,
        CFG_B1  = 3'd5,
        CFG_RW  = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MAC_U_COL = 2'd0,
        MAC_U_ROW = 2'd1,
        MAC_V_COL = 2'd2,
        MAC_V_ROW = 2'd3
    } mac_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_META,
        ST_MAC_UC,
        ST_MAC_UR,
        ST_MAC_VC,
        ST_MAC_VR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     load;
        logic     clip;
        logic     meta;
        logic     mac;
        mac_sel_t mac_sel;
        logic     step;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic meta_hit;
        logic affine;
        logic use_meta;
        logic last;
    } dp_status_t;

endpackage

// ----- rtl/sprite_scanline_texel_generator_top.sv -----
// Top level of the sprite scanline texel generator.
//
// An item is taken when start is high while busy is low. A load item writes one
// row opacity word and leaves busy low, so the next item can follow at once.
// A draw item raises busy and enters the clipping state; a plain draw with
// metadata adds a state that trims the span to its opacity store entry, and an
// affine draw adds the u column, u row, v column and v row steps in which one
// shared multiplier builds the starting u and v sums. After that the block sends
// one pixel per cycle, each marked by strobe for one cycle, with last set on the
// final pixel of the span, and then drops busy. A draw that misses the line or
// the raster returns to idle after clipping and sends nothing.
// The receiver cannot stall; every pixel is taken in the cycle in which it shows.
// Reset restores the configuration registers to their reset values and returns
// the controller to idle; the opacity store holds no defined contents until
// written. Configuration writes are taken at any edge at which wr_en is high.
module sprite_scanline_texel_generator_top import sstg_pkg::*;
#(
    parameter int MAX_LOG_SIZE     = DEF_MAX_LOG_SIZE,
    parameter int MAX_RASTER_WIDTH = DEF_MAX_RASTER_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [11:0] sprite_x,
    input  logic signed [11:0] sprite_y,
    input  logic [2:0]         size_log2,
    input  logic               vertical_flip,
    input  logic               use_metadata,
    input  logic [9:0]         line_y,
    input  logic [5:0]         meta_row,
    input  logic [31:0]        meta_word,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data,
    output logic               strobe,
    output logic [9:0]         screen_x,
    output logic [11:0]        texel_index,
    output logic               needs_alpha,
    output logic               last
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    sstg_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (dp_status),
        .cmd     (dp_cmd),
        .busy    (busy),
        .strobe  (strobe)
    );

    sstg_dp
    #(
        .MAX_LOG_SIZE     (MAX_LOG_SIZE),
        .MAX_RASTER_WIDTH (MAX_RASTER_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .sprite_x      (sprite_x),
        .sprite_y      (sprite_y),
        .size_log2     (size_log2),
        .vertical_flip (vertical_flip),
        .use_metadata  (use_metadata),
        .line_y        (line_y),
        .command       (command),
        .meta_row      (meta_row),
        .meta_word     (meta_word),
        .screen_x      (screen_x),
        .texel_index   (texel_index),
        .needs_alpha   (needs_alpha),
        .last          (last)
    );

endmodule

// ----- rtl/sstg_ctrl.sv -----
// Controller state machine that sequences clipping, metadata, affine setup and pixel output.
module sstg_ctrl import sstg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       strobe
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mac_sel   = MAC_U_COL;
        cmd.capture   = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command_t'(command))
                        CMD_PLAIN, CMD_AFFINE: state_next = ST_CLIP;
                        CMD_LOAD:              cmd.load   = 1'b1;
                        CMD_NONE:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLIP:
            begin
                cmd.clip = 1'b1;
                priority if (!status.hit)
                    state_next = ST_IDLE;
                else if (status.affine)
                    state_next = ST_MAC_UC;
                else if (status.use_meta)
                    state_next = ST_META;
                else
                    state_next = ST_EMIT;
            end
            ST_META:
            begin
                cmd.meta   = 1'b1;
                state_next = status.meta_hit ? ST_EMIT : ST_IDLE;
            end
            ST_MAC_UC:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = MAC_U_COL;
                state_next  = ST_MAC_UR;
            end
            ST_MAC_UR:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = MAC_U_ROW;
                state_next  = ST_MAC_VC;
            end
            ST_MAC_VC:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = MAC_V_COL;
                state_next  = ST_MAC_VR;
            end
            ST_MAC_VR:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = MAC_V_ROW;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.step = 1'b1;
                if (status.last)
                    state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sstg_dp.sv -----
// Datapath with configuration registers, clipping, opacity store, affine setup and span walk.
module sstg_dp import sstg_pkg::*;
#(
    parameter int MAX_LOG_SIZE     = DEF_MAX_LOG_SIZE,
    parameter int MAX_RASTER_WIDTH = DEF_MAX_RASTER_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data,
    input  logic signed [11:0] sprite_x,
    input  logic signed [11:0] sprite_y,
    input  logic [2:0]         size_log2,
    input  logic               vertical_flip,
    input  logic               use_metadata,
    input  logic [9:0]         line_y,
    input  logic [1:0]         command,
    input  logic [5:0]         meta_row,
    input  logic [31:0]        meta_word,
    output logic [9:0]         screen_x,
    output logic [11:0]        texel_index,
    output logic               needs_alpha,
    output logic               last
);

    localparam int SIZE_W = MAX_LOG_SIZE + 1;
    localparam int LG_W   = $clog2(MAX_LOG_SIZE + 1);
    localparam logic [2:0] MAX_LG = 3'(MAX_LOG_SIZE);
    localparam logic signed [CW-1:0] RW_MAX = CW'(MAX_RASTER_WIDTH);

    logic [31:0] a00_reg, a01_reg, b0_reg, a10_reg, a11_reg, b1_reg;
    logic [10:0] rw_reg;

    logic [31:0] meta_mem [META_DEPTH];
    logic [31:0] meta_q_reg;

    logic signed [11:0]      sx_reg;
    logic signed [11:0]      sy_reg;
    logic [LG_W-1:0]         lg_reg;
    logic                    vflip_reg;
    logic                    use_meta_reg;
    logic                    affine_reg;
    logic [9:0]              ly_reg;
    logic [MAX_LOG_SIZE-1:0] row_reg;
    logic [SIZE_W-1:0]       col_reg;
    logic [SIZE_W-1:0]       rem_reg;
    logic                    alpha_reg;
    logic [31:0]             u_reg;
    logic [31:0]             v_reg;

    logic [2:0]              lg_sat;
    logic signed [CW-1:0]    sx_w, sy_w, ly_w, size_w, ty_w, tyf_w, xs_w, tx_w;
    logic signed [CW-1:0]    end_w, rw_w, xe_w, n_w, col_w;
    logic                    hit_y;
    logic [MAX_LOG_SIZE-1:0] row_w;

    logic signed [MW-1:0]    m_start, m_end, tx_m, txn_m, ns_m, ne_m, nn_m;

    logic [SIZE_W-1:0]       c0;
    logic [SIZE_W-1:0]       mac_op;
    logic [31:0]             mac_coef;
    logic [31:0]             prod;

    logic [11:0]             sum_x;
    logic [11:0]             tex_plain;
    logic [11:0]             tex_aff;
    logic [MAX_LOG_SIZE-1:0] msk;
    logic [MAX_LOG_SIZE-1:0] tu;
    logic [MAX_LOG_SIZE-1:0] tv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a00_reg <= COEF_ONE;
            a01_reg <= COEF_ZERO;
            b0_reg  <= COEF_ZERO;
            a10_reg <= COEF_ZERO;
            a11_reg <= COEF_ONE;
            b1_reg  <= COEF_ZERO;
            rw_reg  <= RW_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_A00: a00_reg <= wr_data;
                CFG_A01: a01_reg <= wr_data;
                CFG_B0:  b0_reg  <= wr_data;
                CFG_A10: a10_reg <= wr_data;
                CFG_A11: a11_reg <= wr_data;
                CFG_B1:  b1_reg  <= wr_data;
                CFG_RW:  rw_reg  <= wr_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            meta_mem[meta_row] <= meta_word;
        if (cmd.clip)
            meta_q_reg <= meta_mem[META_AW'(row_w)];
    end

    assign lg_sat = (size_log2 > MAX_LG) ? MAX_LG : size_log2;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg       <= sprite_x;
            sy_reg       <= sprite_y;
            lg_reg       <= LG_W'(lg_sat);
            vflip_reg    <= vertical_flip;
            use_meta_reg <= use_metadata;
            affine_reg   <= (command_t'(command) == CMD_AFFINE);
            ly_reg       <= line_y;
        end
    end

    always_comb
    begin
        sx_w   = {{(CW-12){sx_reg[11]}}, sx_reg};
        sy_w   = {{(CW-12){sy_reg[11]}}, sy_reg};
        ly_w   = {{(CW-10){1'b0}}, ly_reg};
        size_w = {{(CW-1){1'b0}}, 1'b1} << lg_reg;
        ty_w   = ly_w - sy_w;
        tyf_w  = size_w - {{(CW-1){1'b0}}, 1'b1} - ty_w;
        hit_y  = (ty_w >= 0) && (ty_w < size_w);
        xs_w   = (sx_w > 0) ? sx_w : '0;
        tx_w   = xs_w - sx_w;
        end_w  = sx_w + size_w;
        rw_w   = ($signed({{(CW-11){1'b0}}, rw_reg}) > RW_MAX) ? RW_MAX
                 : $signed({{(CW-11){1'b0}}, rw_reg});
        xe_w   = (end_w < rw_w) ? end_w : rw_w;
        n_w    = xe_w - xs_w;
        col_w  = affine_reg ? (tx_w + n_w - {{(CW-1){1'b0}}, 1'b1}) : tx_w;
        row_w  = (vflip_reg && !affine_reg) ? tyf_w[MAX_LOG_SIZE-1:0]
                                            : ty_w[MAX_LOG_SIZE-1:0];
    end

    always_comb
    begin
        m_end   = {{(MW-16){1'b0}}, meta_q_reg[15:0]};
        m_start = {{(MW-15){1'b0}}, meta_q_reg[30:16]};
        tx_m    = {{(MW-SIZE_W){1'b0}}, col_reg};
        txn_m   = tx_m + {{(MW-SIZE_W){1'b0}}, rem_reg};
        ns_m    = (tx_m > m_start) ? tx_m : m_start;
        ne_m    = (txn_m < m_end) ? txn_m : m_end;
        nn_m    = ne_m - ns_m;
    end

    assign c0     = col_reg + {{(SIZE_W-1){1'b0}}, 1'b1};
    assign mac_op = (cmd.mac_sel == MAC_U_COL || cmd.mac_sel == MAC_V_COL)
                    ? c0 : {1'b0, row_reg};

    always_comb
    begin
        unique case (cmd.mac_sel)
            MAC_U_COL: mac_coef = a00_reg;
            MAC_U_ROW: mac_coef = a01_reg;
            MAC_V_COL: mac_coef = a10_reg;
            MAC_V_ROW: mac_coef = a11_reg;
        endcase
    end

    assign prod = mac_coef * {{(32-SIZE_W){1'b0}}, mac_op};

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            row_reg   <= row_w;
            col_reg   <= col_w[SIZE_W-1:0];
            rem_reg   <= n_w[SIZE_W-1:0];
            alpha_reg <= 1'b1;
        end
        else if (cmd.meta)
        begin
            col_reg   <= ns_m[SIZE_W-1:0];
            rem_reg   <= nn_m[SIZE_W-1:0];
            alpha_reg <= ~meta_q_reg[31];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_reg - {{(SIZE_W-1){1'b0}}, 1'b1};
            col_reg <= affine_reg ? col_reg - {{(SIZE_W-1){1'b0}}, 1'b1}
                                  : col_reg + {{(SIZE_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            unique case (cmd.mac_sel)
                MAC_U_COL: u_reg <= b0_reg + prod;
                MAC_U_ROW: u_reg <= u_reg + prod;
                MAC_V_COL: v_reg <= b1_reg + prod;
                MAC_V_ROW: v_reg <= v_reg + prod;
            endcase
        end
        else if (cmd.step)
        begin
            u_reg <= u_reg - a00_reg;
            v_reg <= v_reg - a10_reg;
        end
    end

    always_comb
    begin
        sum_x     = sx_reg + {{(12-SIZE_W){1'b0}}, col_reg};
        tex_plain = {{(12-SIZE_W){1'b0}}, col_reg}
                    + ({{(12-MAX_LOG_SIZE){1'b0}}, row_reg} << lg_reg);
        msk       = size_w[MAX_LOG_SIZE-1:0] - {{(MAX_LOG_SIZE-1){1'b0}}, 1'b1};
        tu        = u_reg[COEF_FRAC +: MAX_LOG_SIZE] & msk;
        tv        = v_reg[COEF_FRAC +: MAX_LOG_SIZE] & msk;
        tex_aff   = ({{(12-MAX_LOG_SIZE){1'b0}}, tv} << lg_reg)
                    | {{(12-MAX_LOG_SIZE){1'b0}}, tu};
    end

    assign screen_x    = sum_x[9:0];
    assign texel_index = affine_reg ? tex_aff : tex_plain;
    assign needs_alpha = alpha_reg;
    assign last        = (rem_reg == {{(SIZE_W-1){1'b0}}, 1'b1});

    assign status.hit      = hit_y && (n_w > 0);
    assign status.meta_hit = (nn_m > 0);
    assign status.affine   = affine_reg;
    assign status.use_meta = use_meta_reg;
    assign status.last     = last;

endmodule

// ----- rtl/sstg_chk.sv -----
// Port-level checker of the sprite scanline texel generator and its bind statement.
module sstg_chk import sstg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       strobe,
    input logic       last
);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("Result transaction shown while the block is idle.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe && !busy)
        else $error("Result transaction follows the final pixel of a span.");

    a_span_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("Gap inside a span before its final pixel.");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_LOAD || command == CMD_NONE) |=> !busy)
        else $error("Load or empty command occupied the block.");

    a_strobe_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> $past(busy))
        else $error("Span started without a setup cycle.");

endmodule

bind sprite_scanline_texel_generator_top sstg_chk u_sstg_chk
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .strobe  (strobe),
    .last    (last)
);

// ----- sim/tb_top.sv -----
// Testbench for the sprite scanline texel generator: directed and random transactions checked per pixel.
`timescale 1ns / 100ps

module tb_top;
    import sstg_pkg::*;

    typedef struct {
        command_t           cmd;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic [2:0]         lg;
        logic               vflip;
        logic               use_md;
        logic [9:0]         line;
        logic [5:0]         row;
        logic [31:0]        word;
    } draw_item_t;

    typedef struct {
        logic [9:0]  screen_x;
        logic [11:0] texel_index;
        logic        needs_alpha;
        logic        last;
    } span_pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         command = CMD_NONE;
    logic signed [11:0] sprite_x = '0;
    logic signed [11:0] sprite_y = '0;
    logic [2:0]         size_log2 = '0;
    logic               vertical_flip = 1'b0;
    logic               use_metadata = 1'b0;
    logic [9:0]         line_y = '0;
    logic [5:0]         meta_row = '0;
    logic [31:0]        meta_word = '0;
    logic               wr_en = 1'b0;
    logic [2:0]         wr_index = CFG_A00;
    logic [31:0]        wr_data = '0;
    logic               strobe;
    logic [9:0]         screen_x;
    logic [11:0]        texel_index;
    logic               needs_alpha;
    logic               last;

    span_pixel_t expected_pixels[$];
    logic [31:0] cfg_model [CFG_RW + 1];
    logic [31:0] opacity_model [META_DEPTH];
    bit          row_loaded [META_DEPTH];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    sprite_scanline_texel_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .sprite_x      (sprite_x),
        .sprite_y      (sprite_y),
        .size_log2     (size_log2),
        .vertical_flip (vertical_flip),
        .use_metadata  (use_metadata),
        .line_y        (line_y),
        .meta_row      (meta_row),
        .meta_word     (meta_word),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .strobe        (strobe),
        .screen_x      (screen_x),
        .texel_index   (texel_index),
        .needs_alpha   (needs_alpha),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 200)
        begin
            $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic int clipped_raster();
        int rw;
        rw = int'(cfg_model[CFG_RW][10:0]);
        return (rw > DEF_MAX_RASTER_WIDTH) ? DEF_MAX_RASTER_WIDTH : rw;
    endfunction

    task automatic predict_span(input draw_item_t it);
        int          sx, sy, lg, size, rw, ty, xs, tx, xe, n, ns, ne, opaque_first, opaque_end;
        logic [31:0] meta, u, v, c0, r0, msk, tu, tv;
        logic        alpha;
        span_pixel_t px;
        if (it.cmd == CMD_LOAD)
        begin
            opacity_model[it.row] = it.word;
            row_loaded[it.row] = 1'b1;
            return;
        end
        if (it.cmd == CMD_NONE)
        begin
            return;
        end
        sx = int'(it.sx);
        sy = int'(it.sy);
        lg = (int'(it.lg) > DEF_MAX_LOG_SIZE) ? DEF_MAX_LOG_SIZE : int'(it.lg);
        size = 1 << lg;
        rw = clipped_raster();
        ty = int'(it.line) - sy;
        if (ty < 0 || ty >= size)
        begin
            return;
        end
        xs = (sx > 0) ? sx : 0;
        tx = xs - sx;
        xe = (sx + size < rw) ? sx + size : rw;
        n = xe - xs;
        if (n <= 0)
        begin
            return;
        end
        if (it.cmd == CMD_PLAIN)
        begin
            alpha = 1'b1;
            if (it.vflip)
            begin
                ty = size - 1 - ty;
            end
            if (it.use_md)
            begin
                meta = opacity_model[ty[5:0]];
                opaque_end = int'(meta[15:0]);
                opaque_first = int'(meta[30:16]);
                ns = (tx > opaque_first) ? tx : opaque_first;
                ne = (tx + n < opaque_end) ? tx + n : opaque_end;
                tx = ns;
                n = ne - ns;
                if (n <= 0)
                begin
                    return;
                end
                alpha = ~meta[31];
            end
            for (int i = 0; i < n; i++)
            begin
                px.screen_x = 10'(sx + tx + i);
                px.texel_index = 12'(tx + i + ty * size);
                px.needs_alpha = alpha;
                px.last = (i == n - 1);
                expected_pixels.push_back(px);
            end
        end
        else
        begin
            // The affine walk starts one column past the span and steps back.
            c0 = 32'(tx + n);
            r0 = 32'(ty);
            u = cfg_model[CFG_A00] * c0 + cfg_model[CFG_A01] * r0 + cfg_model[CFG_B0];
            v = cfg_model[CFG_A10] * c0 + cfg_model[CFG_A11] * r0 + cfg_model[CFG_B1];
            msk = 32'(size - 1);
            for (int k = 0; k < n; k++)
            begin
                tu = (u >> COEF_FRAC) & msk;
                tv = (v >> COEF_FRAC) & msk;
                px.screen_x = 10'(xs + n - 1 - k);
                px.texel_index = 12'((tv << lg) | tu);
                px.needs_alpha = 1'b1;
                px.last = (k == n - 1);
                expected_pixels.push_back(px);
                u = u - cfg_model[CFG_A00];
                v = v - cfg_model[CFG_A10];
            end
        end
    endtask

    task automatic send_item(input draw_item_t item_in);
        draw_item_t it;
        int         lg, size, ty;
        it = item_in;
        // Never let a plain draw read an opacity row that has not been loaded.
        if (it.cmd == CMD_PLAIN && it.use_md)
        begin
            lg = (int'(it.lg) > DEF_MAX_LOG_SIZE) ? DEF_MAX_LOG_SIZE : int'(it.lg);
            size = 1 << lg;
            ty = int'(it.line) - int'(it.sy);
            if (ty >= 0 && ty < size)
            begin
                if (it.vflip)
                begin
                    ty = size - 1 - ty;
                end
                if (!row_loaded[ty[5:0]])
                begin
                    it.use_md = 1'b0;
                end
            end
        end
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        command <= it.cmd;
        sprite_x <= it.sx;
        sprite_y <= it.sy;
        size_log2 <= it.lg;
        vertical_flip <= it.vflip;
        use_metadata <= it.use_md;
        line_y <= it.line;
        meta_row <= it.row;
        meta_word <= it.word;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        predict_span(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_config(input logic [31:0] a00, input logic [31:0] a01,
                                input logic [31:0] b0, input logic [31:0] a10,
                                input logic [31:0] a11, input logic [31:0] b1,
                                input logic [10:0] rw);
        logic [31:0] vals [CFG_RW + 1];
        vals[CFG_A00] = a00;
        vals[CFG_A01] = a01;
        vals[CFG_B0] = b0;
        vals[CFG_A10] = a10;
        vals[CFG_A11] = a11;
        vals[CFG_B1] = b1;
        vals[CFG_RW] = {21'($urandom), rw};
        for (int i = CFG_A00; i <= CFG_RW; i++)
        begin
            wr_en <= 1'b1;
            wr_index <= cfg_index_t'(i);
            wr_data <= vals[i];
            @(posedge clk);
            cfg_model[i] = vals[i];
        end
        wr_en <= 1'b0;
    endtask

    function automatic draw_item_t make_draw(input command_t cmd, input int x, input int y,
                                             input int lg, input int line, input bit vflip,
                                             input bit use_md);
        draw_item_t it;
        it.cmd = cmd;
        it.sx = 12'(x);
        it.sy = 12'(y);
        it.lg = 3'(lg);
        it.vflip = vflip;
        it.use_md = use_md;
        it.line = 10'(line);
        it.row = 6'($urandom);
        it.word = $urandom;
        return it;
    endfunction

    function automatic draw_item_t make_load(input int row, input logic [31:0] word);
        draw_item_t it;
        it = make_draw(CMD_LOAD, int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                       int'($urandom_range(0, 7)), int'($urandom_range(0, 1023)),
                       1'($urandom), 1'($urandom));
        it.row = 6'(row);
        it.word = word;
        return it;
    endfunction

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return COEF_ZERO;
            3: return $urandom;
            default: return 32'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
        endcase
    endfunction

    function automatic draw_item_t random_item();
        draw_item_t it;
        int         pick, lg, size, rw;
        it.cmd = command_t'($urandom_range(0, 3));
        it.sx = 12'($urandom);
        it.sy = 12'($urandom);
        it.lg = 3'($urandom);
        it.vflip = 1'($urandom);
        it.use_md = 1'($urandom);
        it.line = 10'($urandom);
        it.row = 6'($urandom);
        it.word = $urandom;
        pick = $urandom_range(0, 99);
        if (pick >= 15 && pick < 32)
        begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(0, 1) == 1)
            begin
                it.word = {1'($urandom), 15'($urandom_range(0, 40)), 16'($urandom_range(0, 72))};
            end
        end
        else if (pick >= 32)
        begin
            // Well-formed draw: the sprite covers the line and lies near the raster.
            it.cmd = ($urandom_range(0, 1) == 1) ? CMD_AFFINE : CMD_PLAIN;
            lg = (int'(it.lg) > DEF_MAX_LOG_SIZE) ? DEF_MAX_LOG_SIZE : int'(it.lg);
            size = 1 << lg;
            rw = clipped_raster();
            it.sy = 12'(int'(it.line) - int'($urandom_range(0, size - 1)));
            it.sx = 12'(int'($urandom_range(0, rw + size)) - size);
        end
        return it;
    endfunction

    task automatic test_loads_and_plain();
        send_item(make_load(0, {1'b1, 15'd2, 16'd6}));
        send_item(make_load(3, {1'b0, 15'd0, 16'hffff}));
        send_item(make_load(63, 32'hffff_ffff));
        send_item(make_load(5, 32'h0000_0000));
        send_item(make_draw(CMD_PLAIN, 0, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_draw(CMD_PLAIN, -2048, -2048, 6, 1023, 1'b0, 1'b0));
        send_item(make_draw(CMD_PLAIN, -10, 0, 7, 3, 1'b1, 1'b0));
        send_item(make_draw(CMD_PLAIN, 600, 1000, 6, 1023, 1'b0, 1'b0));
        send_item(make_draw(CMD_PLAIN, 2047, 2047, 6, 0, 1'b1, 1'b0));
        send_item(make_draw(CMD_NONE, 5, 5, 3, 5, 1'b0, 1'b0));
        send_item(make_draw(CMD_AFFINE, 100, 0, 2, 1, 1'b0, 1'b0));
    endtask

    task automatic test_metadata_span();
        send_item(make_draw(CMD_PLAIN, 10, 5, 3, 5, 1'b0, 1'b1));
        send_item(make_draw(CMD_PLAIN, 20, 4, 2, 4, 1'b1, 1'b1));
        send_item(make_draw(CMD_PLAIN, 0, 0, 6, 63, 1'b0, 1'b1));
        send_item(make_draw(CMD_PLAIN, 0, 0, 6, 5, 1'b0, 1'b1));
    endtask

    task automatic test_affine_walk();
        settle();
        apply_config(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'hffff_0000,
                     32'h0001_8000, 32'hdead_beef, 11'd2047);
        send_item(make_draw(CMD_AFFINE, -5, 10, 6, 40, 1'b0, 1'b0));
        send_item(make_draw(CMD_AFFINE, 7, 9, 0, 9, 1'b0, 1'b0));
        send_item(make_draw(CMD_AFFINE, 1020, 0, 4, 15, 1'b0, 1'b0));
        send_item(make_draw(CMD_AFFINE, 30, 2, 3, 4, 1'b1, 1'b1));
    endtask

    task automatic test_raster_limits();
        settle();
        apply_config(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO, 11'd0);
        send_item(make_draw(CMD_PLAIN, 0, 0, 5, 3, 1'b0, 1'b0));
        settle();
        apply_config(random_coef(), random_coef(), random_coef(), random_coef(),
                     random_coef(), random_coef(), 11'd1);
        send_item(make_draw(CMD_PLAIN, 0, 0, 5, 3, 1'b0, 1'b0));
        send_item(make_draw(CMD_AFFINE, -3, 2, 2, 2, 1'b0, 1'b0));
        settle();
        apply_config(cfg_model[CFG_A00], cfg_model[CFG_A01], cfg_model[CFG_B0],
                     cfg_model[CFG_A10], cfg_model[CFG_A11], cfg_model[CFG_B1], 11'd1024);
        send_item(make_draw(CMD_PLAIN, 1000, 500, 6, 530, 1'b1, 1'b0));
        send_item(make_draw(CMD_AFFINE, 990, 500, 6, 563, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic();
        int phase_rw [6];
        phase_rw = '{640, 1024, 0, 2047, 64, 1024};
        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            if (phase == 0)
            begin
                apply_config(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                             11'(phase_rw[phase]));
            end
            else
            begin
                apply_config(random_coef(), random_coef(), random_coef(), random_coef(),
                             random_coef(), random_coef(),
                             (phase_rw[phase] == 0) ? 11'($urandom_range(1, 2047))
                                                    : 11'(phase_rw[phase]));
            end
            gaps_on = (phase != 5);
            repeat (75) send_item(random_item());
        end
    endtask

    always @(posedge clk)
    begin : pixel_check
        span_pixel_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel, screen_x %0d", screen_x));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (screen_x !== want.screen_x)
                begin
                    report_mismatch($sformatf("screen_x %0d, want %0d", screen_x, want.screen_x));
                end
                if (texel_index !== want.texel_index)
                begin
                    report_mismatch($sformatf("texel_index %0d, want %0d at x %0d",
                                              texel_index, want.texel_index, want.screen_x));
                end
                if (needs_alpha !== want.needs_alpha)
                begin
                    report_mismatch($sformatf("needs_alpha %b, want %b at x %0d",
                                              needs_alpha, want.needs_alpha, want.screen_x));
                end
                if (last !== want.last)
                begin
                    report_mismatch($sformatf("last %b, want %b at x %0d",
                                              last, want.last, want.screen_x));
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        cfg_model[CFG_A00] = COEF_ONE;
        cfg_model[CFG_A01] = COEF_ZERO;
        cfg_model[CFG_B0] = COEF_ZERO;
        cfg_model[CFG_A10] = COEF_ZERO;
        cfg_model[CFG_A11] = COEF_ONE;
        cfg_model[CFG_B1] = COEF_ZERO;
        cfg_model[CFG_RW] = 32'(RW_RESET);
        for (int i = 0; i < META_DEPTH; i++)
        begin
            opacity_model[i] = '0;
            row_loaded[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_loads_and_plain();
        test_metadata_span();
        test_affine_walk();
        test_raster_limits();
        test_random_traffic();
        settle();
        if (mismatch_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sstg_pkg.sv
rtl/sstg_ctrl.sv
rtl/sstg_dp.sv
rtl/sprite_scanline_texel_generator_top.sv
rtl/sstg_chk.sv
sim/tb_top.sv
